// File: hw/rtl/ssll_pkg.sv
`default_nettype none

package ssll_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam int unsigned ACTION_W  = 3;
	localparam int unsigned KEY_W     = 32;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned SLOT_W    = 6;
	localparam int unsigned COUNT_W   = 7;

	typedef logic [ACTION_W-1:0]         action_t;
	typedef logic signed [KEY_W-1:0]     key_t;
	typedef logic [PAYLOAD_W-1:0]        payload_t;
	typedef logic [STATUS_W-1:0]         status_t;
	typedef logic [SLOT_W-1:0]           slot_t;
	typedef logic [COUNT_W-1:0]          count_t;

	localparam action_t ACT_CLEAR  = 3'd0;
	localparam action_t ACT_INSERT = 3'd1;
	localparam action_t ACT_DELETE = 3'd2;
	localparam action_t ACT_SEARCH = 3'd3;
	localparam action_t ACT_SIZE   = 3'd4;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_DUP     = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

	typedef enum logic [1:0] {
		SLOT_ZERO,
		SLOT_CUR,
		SLOT_FRESH
	} slot_sel_t;

	typedef struct packed {
		logic      latch;
		logic      clear;
		logic      walk_start;
		logic      walk_step;
		logic      ins_a;
		logic      ins_b;
		logic      del_a;
		logic      del_b;
		logic      res_we;
		status_t   res_status;
		slot_sel_t res_slot;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    pool_full;
		logic    head_nil;
		logic    key_lt;
		logic    key_eq;
		logic    next_nil;
		logic    out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssll_if.sv
`default_nettype none

interface ssll_req_if;
	logic                valid;
	logic                ready;
	ssll_pkg::action_t   action;
	ssll_pkg::key_t      key;
	ssll_pkg::payload_t  payload;

	modport source (output valid, action, key, payload, input ready);
	modport sink   (input valid, action, key, payload, output ready);
endinterface

interface ssll_rsp_if;
	logic               valid;
	logic               ready;
	ssll_pkg::status_t  status;
	ssll_pkg::slot_t    slot_index;
	ssll_pkg::count_t   element_count;

	modport source (output valid, status, slot_index, element_count, input ready);
	modport sink   (input valid, status, slot_index, element_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ssll_ctrl.sv
`default_nettype none

module ssll_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire ssll_pkg::dp_stat_t stat,
	output ssll_pkg::dp_cmd_t       cmd
);
	import ssll_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		DISPATCH,
		WALK,
		INS_A,
		INS_B,
		DEL_A,
		DEL_B,
		FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		logic hit;
		logic miss;
		hit     = 1'b0;
		miss    = 1'b0;
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (ready_q && req_valid) begin
					cmd.latch = 1'b1;
					state_d   = DISPATCH;
				end
			end
			DISPATCH: begin
				cmd.res_we     = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_slot   = SLOT_ZERO;
				state_d        = FIN;
				unique case (stat.action) inside
					ACT_CLEAR: cmd.clear = 1'b1;
					ACT_INSERT: begin
						if (stat.pool_full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.walk_start = 1'b1;
							state_d        = stat.head_nil ? INS_A : WALK;
						end
					end
					ACT_DELETE, ACT_SEARCH: begin
						cmd.walk_start = 1'b1;
						if (stat.head_nil) begin
							cmd.res_status = ST_MISSING;
						end else begin
							state_d = WALK;
						end
					end
					default: ;
				endcase
			end
			WALK: begin
				if (stat.key_lt) begin
					cmd.walk_step = 1'b1;
					miss          = stat.next_nil;
				end else begin
					hit  = stat.key_eq;
					miss = !stat.key_eq;
				end
				if (miss) begin
					if (stat.action == ACT_INSERT) begin
						state_d = INS_A;
					end else begin
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_MISSING;
						cmd.res_slot   = SLOT_ZERO;
						state_d        = FIN;
					end
				end else if (hit) begin
					unique case (stat.action) inside
						ACT_INSERT: begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_DUP;
							cmd.res_slot   = SLOT_ZERO;
							state_d        = FIN;
						end
						ACT_DELETE: state_d = DEL_A;
						default: begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_OK;
							cmd.res_slot   = SLOT_CUR;
							state_d        = FIN;
						end
					endcase
				end
			end
			INS_A: begin
				cmd.ins_a      = 1'b1;
				cmd.res_we     = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_slot   = SLOT_FRESH;
				state_d        = INS_B;
			end
			INS_B: begin
				cmd.ins_b = 1'b1;
				state_d   = FIN;
			end
			DEL_A: begin
				cmd.del_a      = 1'b1;
				cmd.res_we     = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_slot   = SLOT_ZERO;
				state_d        = DEL_B;
			end
			DEL_B: begin
				cmd.del_b = 1'b1;
				state_d   = FIN;
			end
			FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == IDLE);
		end
	end

	assign req_ready = ready_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q == (state_q == IDLE))
		else $error("ready out of step with idle state");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == DISPATCH)
		else $error("accepted transfer not dispatched");

	a_ins_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_b |-> $past(cmd.ins_a))
		else $error("insert relink without allocation");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ssll_dp.sv
`default_nettype none

module ssll_dp #(
	parameter int unsigned CAPACITY = ssll_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssll_pkg::action_t  action,
	input  wire ssll_pkg::key_t     key,
	input  wire ssll_pkg::payload_t payload,
	input  wire ssll_pkg::dp_cmd_t  cmd,
	output ssll_pkg::dp_stat_t      stat,
	ssll_rsp_if.source              rsp
);
	import ssll_pkg::*;

	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = IW + 1;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	action_t  action_q;
	key_t     key_q;
	payload_t payload_q;

	logic [LW-1:0] list_head_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] fill_q;
	logic [LW-1:0] count_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	status_t       status_q;
	logic [LW-1:0] slot_q;

	logic [LW-1:0] link_mem [CAPACITY];
	key_t          key_mem  [CAPACITY];
	payload_t      pay_mem  [CAPACITY];

	logic [IW-1:0] rd_addr_q;
	logic          virt_q;
	key_t          key_rd_q;
	logic [LW-1:0] link_rd_q;
	logic [LW-1:0] link_rd;

	logic          rd_en;
	logic [LW-1:0] rd_link;
	logic          lw_en;
	logic [IW-1:0] lw_addr;
	logic [LW-1:0] lw_data;
	logic          prev_nil;

	logic     out_valid_q;
	status_t  out_status_q;
	slot_t    out_slot_q;
	count_t   out_count_q;

	assign link_rd  = virt_q ? (LW'(rd_addr_q) + LW'(1)) : link_rd_q;
	assign prev_nil = (prev_q >= NIL);

	always_comb begin
		rd_link = free_head_q;
		if (cmd.walk_start) begin
			rd_link = list_head_q;
		end else if (cmd.walk_step) begin
			rd_link = link_rd;
		end
		rd_en = (cmd.walk_start || cmd.walk_step || cmd.ins_a) && (rd_link < NIL);
	end

	always_comb begin
		lw_en   = 1'b0;
		lw_addr = prev_q[IW-1:0];
		lw_data = free_head_q;
		if (cmd.ins_a && !prev_nil) begin
			lw_en = 1'b1;
		end else if (cmd.ins_b) begin
			lw_en   = 1'b1;
			lw_addr = slot_q[IW-1:0];
			lw_data = cur_q;
		end else if (cmd.del_a && !prev_nil) begin
			lw_en   = 1'b1;
			lw_data = link_rd;
		end else if (cmd.del_b) begin
			lw_en   = 1'b1;
			lw_addr = cur_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_q  <= key_mem[rd_link[IW-1:0]];
			link_rd_q <= link_mem[rd_link[IW-1:0]];
			rd_addr_q <= rd_link[IW-1:0];
			virt_q    <= (rd_link >= fill_q);
		end
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (cmd.ins_a) begin
			key_mem[free_head_q[IW-1:0]] <= key_q;
			pay_mem[free_head_q[IW-1:0]] <= payload_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q <= NIL;
			free_head_q <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				list_head_q <= NIL;
				free_head_q <= '0;
				fill_q      <= '0;
				count_q     <= '0;
			end
			if (cmd.ins_a) begin
				if (prev_nil) begin
					list_head_q <= free_head_q;
				end
				if (free_head_q == fill_q) begin
					fill_q <= fill_q + LW'(1);
				end
			end
			if (cmd.ins_b) begin
				free_head_q <= link_rd;
				count_q     <= count_q + LW'(1);
			end
			if (cmd.del_a && prev_nil) begin
				list_head_q <= link_rd;
			end
			if (cmd.del_b) begin
				free_head_q <= cur_q;
				count_q     <= count_q - LW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q  <= action;
			key_q     <= key;
			payload_q <= payload;
		end
		if (cmd.walk_start) begin
			cur_q  <= list_head_q;
			prev_q <= NIL;
		end else if (cmd.walk_step) begin
			cur_q  <= link_rd;
			prev_q <= cur_q;
		end
		if (cmd.res_we) begin
			status_q <= cmd.res_status;
			case (cmd.res_slot)
				SLOT_CUR:   slot_q <= cur_q;
				SLOT_FRESH: slot_q <= free_head_q;
				default:    slot_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_slot_q   <= SLOT_W'(slot_q);
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	always_comb begin
		stat.action    = action_q;
		stat.pool_full = (free_head_q >= NIL);
		stat.head_nil  = (list_head_q >= NIL);
		stat.key_lt    = (key_rd_q < key_q);
		stat.key_eq    = (key_rd_q == key_q);
		stat.next_nil  = (link_rd >= NIL);
		stat.out_free  = !out_valid_q || rsp.ready;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot_index    = out_slot_q;
	assign rsp.element_count = out_count_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL)
		else $error("element count beyond capacity");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NIL)
		else $error("fill mark beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q >= NIL) == (count_q == NIL))
		else $error("free chain empty out of step with element count");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sorted_static_linked_list.sv
// channel  dir  handshake    fields
// req      in   valid/ready  action, key, payload
// rsp      out  valid/ready  status, slot_index, element_count
//
// One request at a time. Clear, size query and unused codes go from dispatch straight
// to the result; search first walks the list, insert and delete walk it and then
// pass through INS_A, INS_B or DEL_A, DEL_B. The walk covers at most CAPACITY slots,
// one per cycle through the registered read port of the link and key memories.
// Reset gives an empty list at once; slots at or above a fill mark count as chained.
// rsp holds a result register: a new request is taken while it waits, and the
// next result waits in the controller until rsp is free.

`default_nettype none

module sorted_static_linked_list #(
	parameter int unsigned CAPACITY = ssll_pkg::CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssll_req_if.sink   req,
	ssll_rsp_if.source rsp
);
	import ssll_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ssll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssll_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.action  (req.action),
		.key     (req.key),
		.payload (req.payload),
		.cmd     (cmd),
		.stat    (stat),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
